// File: rtl/pccp_pkg.sv
// Shared types, constants and helpers for the printer control code parser.
// No dependencies; imported by every module of the block.
package pccp_pkg;

    // Width of the newline run and expanded character counters
    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Result commands
    localparam logic [3:0] CMD_CR      = 4'd0;
    localparam logic [3:0] CMD_LF      = 4'd1;
    localparam logic [3:0] CMD_CRLF    = 4'd2;
    localparam logic [3:0] CMD_NEWPAGE = 4'd3;
    localparam logic [3:0] CMD_CHAR    = 4'd4;
    localparam logic [3:0] CMD_STRETCH = 4'd5;
    localparam logic [3:0] CMD_WEIGHT  = 4'd6;
    localparam logic [3:0] CMD_SLANT   = 4'd7;
    localparam logic [3:0] CMD_USEFONT = 4'd8;
    localparam logic [3:0] CMD_SPACING = 4'd9;
    localparam logic [3:0] CMD_TAB     = 4'd10;
    localparam logic [3:0] CMD_GCOL    = 4'd11;
    localparam logic [3:0] CMD_GEND    = 4'd12;

    // Escape sequence phases
    localparam logic [2:0] PH_ENTERED   = 3'd0;
    localparam logic [2:0] PH_UNDERLINE = 3'd1;
    localparam logic [2:0] PH_SPACING   = 3'd2;
    localparam logic [2:0] PH_TAB       = 3'd3;
    localparam logic [2:0] PH_QUALITY   = 3'd4;
    localparam logic [2:0] PH_GRAPHICS  = 3'd5;

    // Stream byte codes
    localparam logic [7:0] BYTE_LF        = 8'h0a;
    localparam logic [7:0] BYTE_FF        = 8'h0c;
    localparam logic [7:0] BYTE_CR        = 8'h0d;
    localparam logic [7:0] BYTE_SO        = 8'h0e;
    localparam logic [7:0] BYTE_SI        = 8'h0f;
    localparam logic [7:0] BYTE_DC2       = 8'h12;
    localparam logic [7:0] BYTE_DC4       = 8'h14;
    localparam logic [7:0] BYTE_ESC       = 8'h1b;
    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] ESC_GRAPHICS   = 8'h2a;
    localparam logic [7:0] ESC_UNDERLINE  = 8'h2d;
    localparam logic [7:0] ESC_SPACING    = 8'h33;
    localparam logic [7:0] ESC_ITALIC_ON  = 8'h34;
    localparam logic [7:0] ESC_ITALIC_OFF = 8'h35;
    localparam logic [7:0] ESC_TAB        = 8'h44;
    localparam logic [7:0] ESC_BOLD_ON    = 8'h45;
    localparam logic [7:0] ESC_BOLD_OFF   = 8'h46;
    localparam logic [7:0] ESC_QUALITY    = 8'h78;

    // Configuration register indexes
    localparam logic REG_PAGE_BREAK = 1'b0;
    localparam logic REG_EXP_BOLD   = 1'b1;

    // Result slots of one job, emitted lowest first
    localparam int SLOT_PAGE = 0;
    localparam int SLOT_CRLF = 1;
    localparam int SLOT_CR   = 2;
    localparam int SLOT_PAD  = 3;
    localparam int SLOT_MAIN = 4;
    localparam int SLOT_SEC  = 5;
    localparam int NUM_SLOTS = 6;

    // All results caused by one input byte
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           crlf_rep;
        logic [7:0]           pad_rep;
        logic [3:0]           main_cmd;
        logic [23:0]          main_arg;
        logic [3:0]           sec_cmd;
        logic [15:0]          sec_arg;
    } job_t;

    // Clip a counter to the 8-bit repeat field
    function automatic logic [7:0] sat_rep(input logic [COUNT_BITS-1:0] v);
        logic [16:0] w;
        begin
            w = 17'(v);
            sat_rep = (w > 17'd255) ? 8'hff : w[7:0];
        end
    endfunction

endpackage

// File: rtl/pccp_front.sv
// Front part: accepts stream bytes, tracks parser state and builds one job per byte.
// Depends on pccp_pkg; holds the configuration registers.
module pccp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] stream_byte
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wdata,
    input  logic              q_full,
    output logic              q_push,
    output pccp_pkg::job_t    q_job
);
    import pccp_pkg::*;

    logic                  accept;
    logic [7:0]            c;
    job_t                  job;
    logic                  do_flush;
    logic                  pg_hit;
    logic [7:0]            flush_rep;
    logic [16:0]           run_w;
    logic [15:0]           new_cols;
    logic [23:0]           acc_or;
    logic [17:0]           gidx_inc;

    logic [7:0]            page_break_reg;
    logic                  exp_bold_reg;

    logic                  in_escape_reg,   in_escape_next;
    logic [2:0]            phase_reg,       phase_next;
    logic                  cr_pending_reg,  cr_pending_next;
    logic [COUNT_BITS-1:0] nl_run_reg,      nl_run_next;
    logic                  first_page_reg,  first_page_next;
    logic                  exp_on_reg,      exp_on_next;
    logic [COUNT_BITS-1:0] exp_chars_reg,   exp_chars_next;
    logic [17:0]           gidx_reg,        gidx_next;
    logic [1:0]            ggroup_reg,      ggroup_next;
    logic [17:0]           glimit_reg,      glimit_next;
    logic [15:0]           gcols_reg,       gcols_next;
    logic [23:0]           gacc_reg,        gacc_next;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    // Newline run flush: page break test and clipped run length
    assign run_w     = 17'(nl_run_reg);
    assign pg_hit    = run_w >= 17'(page_break_reg);
    assign flush_rep = pg_hit ? page_break_reg : sat_rep(nl_run_reg);

    assign new_cols = {c, gcols_reg[7:0]};
    assign gidx_inc = gidx_reg + 18'd1;

    // Column byte merged at its place in the 24-bit column
    always_comb begin
        case (ggroup_reg)
            2'd0:    acc_or = gacc_reg | {c, 16'h0000};
            2'd1:    acc_or = gacc_reg | {8'h00, c, 8'h00};
            default: acc_or = gacc_reg | {16'h0000, c};
        endcase
    end

    // Parser next state and job contents
    always_comb begin
        in_escape_next  = in_escape_reg;
        phase_next      = phase_reg;
        cr_pending_next = cr_pending_reg;
        nl_run_next     = nl_run_reg;
        first_page_next = first_page_reg;
        exp_on_next     = exp_on_reg;
        exp_chars_next  = exp_chars_reg;
        gidx_next       = gidx_reg;
        ggroup_next     = ggroup_reg;
        glimit_next     = glimit_reg;
        gcols_next      = gcols_reg;
        gacc_next       = gacc_reg;
        job             = '0;
        do_flush        = 1'b0;

        if (accept) begin
            if (in_escape_reg) begin
                if (phase_reg == PH_ENTERED) begin
                    // Command byte right after ESC
                    job.mask[SLOT_SEC] = 1'b1;
                    job.sec_cmd        = CMD_USEFONT;
                    in_escape_next     = 1'b0;
                    case (c)
                        ESC_BOLD_ON, ESC_BOLD_OFF: begin
                            job.mask[SLOT_MAIN] = 1'b1;
                            job.main_cmd        = CMD_WEIGHT;
                            job.main_arg        = {23'd0, c == ESC_BOLD_ON};
                        end
                        ESC_ITALIC_ON, ESC_ITALIC_OFF: begin
                            job.mask[SLOT_MAIN] = 1'b1;
                            job.main_cmd        = CMD_SLANT;
                            job.main_arg        = {23'd0, c == ESC_ITALIC_ON};
                        end
                        ESC_GRAPHICS: begin
                            gidx_next      = '0;
                            phase_next     = PH_GRAPHICS;
                            in_escape_next = 1'b1;
                        end
                        ESC_UNDERLINE: begin
                            phase_next     = PH_UNDERLINE;
                            in_escape_next = 1'b1;
                        end
                        ESC_SPACING: begin
                            phase_next     = PH_SPACING;
                            in_escape_next = 1'b1;
                        end
                        ESC_TAB: begin
                            phase_next     = PH_TAB;
                            in_escape_next = 1'b1;
                        end
                        ESC_QUALITY: begin
                            phase_next     = PH_QUALITY;
                            in_escape_next = 1'b1;
                        end
                        default: ;
                    endcase
                end else begin
                    case (phase_reg)
                        PH_SPACING: begin
                            job.mask[SLOT_MAIN] = 1'b1;
                            job.main_cmd        = CMD_SPACING;
                            job.main_arg        = {16'h0000, c};
                            in_escape_next      = 1'b0;
                        end
                        PH_TAB: begin
                            if (c == 8'h00) begin
                                in_escape_next = 1'b0;
                            end else begin
                                job.mask[SLOT_MAIN] = 1'b1;
                                job.main_cmd        = CMD_TAB;
                                job.main_arg        = {16'h0000, c};
                            end
                        end
                        PH_GRAPHICS: begin
                            if (gidx_reg == 18'd0) begin
                                // mode byte, ignored
                                gidx_next = 18'd1;
                            end else if (gidx_reg == 18'd1) begin
                                gcols_next = {8'h00, c};
                                gidx_next  = 18'd2;
                            end else if (gidx_reg == 18'd2) begin
                                gcols_next  = new_cols;
                                gidx_next   = 18'd3;
                                gacc_next   = '0;
                                ggroup_next = 2'd0;
                                glimit_next = 18'({new_cols, 1'b0}) + 18'(new_cols) + 18'd3;
                                if (new_cols == 16'h0000) begin
                                    job.mask[SLOT_SEC] = 1'b1;
                                    job.sec_cmd        = CMD_GEND;
                                    job.sec_arg        = '0;
                                    in_escape_next     = 1'b0;
                                end
                            end else begin
                                // column data, three bytes per column
                                if (ggroup_reg == 2'd2) begin
                                    job.mask[SLOT_MAIN] = 1'b1;
                                    job.main_cmd        = CMD_GCOL;
                                    job.main_arg        = acc_or;
                                    gacc_next           = '0;
                                    ggroup_next         = 2'd0;
                                end else begin
                                    gacc_next   = acc_or;
                                    ggroup_next = ggroup_reg + 2'd1;
                                end
                                gidx_next = gidx_inc;
                                if (gidx_inc >= glimit_reg) begin
                                    job.mask[SLOT_SEC] = 1'b1;
                                    job.sec_cmd        = CMD_GEND;
                                    job.sec_arg        = gcols_reg;
                                    in_escape_next     = 1'b0;
                                end
                            end
                        end
                        default: in_escape_next = 1'b0;
                    endcase
                end
            end else if (c == BYTE_CR) begin
                if (cr_pending_reg) begin
                    do_flush          = 1'b1;
                    job.mask[SLOT_CR] = 1'b1;
                end else begin
                    cr_pending_next = 1'b1;
                end
            end else if (c == BYTE_LF) begin
                if (cr_pending_reg) begin
                    cr_pending_next = 1'b0;
                    if (nl_run_reg != COUNT_MAX)
                        nl_run_next = nl_run_reg + 1'b1;
                end else begin
                    do_flush            = 1'b1;
                    job.mask[SLOT_MAIN] = 1'b1;
                    job.main_cmd        = CMD_LF;
                end
            end else begin
                do_flush          = 1'b1;
                job.mask[SLOT_CR] = cr_pending_reg;
                cr_pending_next   = 1'b0;
                case (c)
                    BYTE_SO: begin
                        exp_on_next         = 1'b1;
                        exp_chars_next      = '0;
                        job.mask[SLOT_MAIN] = 1'b1;
                        if (!exp_bold_reg) begin
                            job.main_cmd = CMD_STRETCH;
                            job.main_arg = 24'd2;
                        end else begin
                            job.main_cmd       = CMD_WEIGHT;
                            job.main_arg       = 24'd1;
                            job.mask[SLOT_SEC] = 1'b1;
                            job.sec_cmd        = CMD_USEFONT;
                        end
                    end
                    BYTE_DC4: begin
                        if (exp_on_reg) begin
                            job.mask[SLOT_PAD]  = exp_bold_reg && (exp_chars_reg != '0);
                            job.pad_rep         = sat_rep(exp_chars_reg);
                            exp_on_next         = 1'b0;
                            job.mask[SLOT_MAIN] = 1'b1;
                            job.main_cmd        = CMD_WEIGHT;
                            job.mask[SLOT_SEC]  = 1'b1;
                            job.sec_cmd         = CMD_USEFONT;
                        end
                    end
                    BYTE_SI, BYTE_DC2: ;
                    BYTE_FF: begin
                        job.mask[SLOT_MAIN] = 1'b1;
                        job.main_cmd        = CMD_NEWPAGE;
                    end
                    BYTE_ESC: begin
                        in_escape_next = 1'b1;
                        phase_next     = PH_ENTERED;
                    end
                    default: begin
                        if (exp_on_reg && exp_chars_reg != COUNT_MAX)
                            exp_chars_next = exp_chars_reg + 1'b1;
                        job.mask[SLOT_MAIN] = 1'b1;
                        job.main_cmd        = CMD_CHAR;
                        job.main_arg        = {16'h0000, c};
                    end
                endcase
            end

            // Pending newline run goes out ahead of everything else
            if (do_flush) begin
                if (pg_hit) begin
                    first_page_next     = 1'b0;
                    job.mask[SLOT_PAGE] = !first_page_reg;
                end
                job.mask[SLOT_CRLF] = (flush_rep != 8'h00);
                job.crlf_rep        = flush_rep;
                nl_run_next         = '0;
            end
        end
    end

    assign q_push = accept && (job.mask != '0);
    assign q_job  = job;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_break_reg <= 8'd11;
            exp_bold_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PAGE_BREAK: page_break_reg <= cfg_wdata;
                REG_EXP_BOLD:   exp_bold_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_escape_reg  <= 1'b0;
            phase_reg      <= PH_ENTERED;
            cr_pending_reg <= 1'b0;
            nl_run_reg     <= '0;
            first_page_reg <= 1'b1;
            exp_on_reg     <= 1'b0;
            exp_chars_reg  <= '0;
            gidx_reg       <= '0;
            ggroup_reg     <= 2'd0;
            glimit_reg     <= '0;
            gcols_reg      <= '0;
            gacc_reg       <= '0;
        end else begin
            in_escape_reg  <= in_escape_next;
            phase_reg      <= phase_next;
            cr_pending_reg <= cr_pending_next;
            nl_run_reg     <= nl_run_next;
            first_page_reg <= first_page_next;
            exp_on_reg     <= exp_on_next;
            exp_chars_reg  <= exp_chars_next;
            gidx_reg       <= gidx_next;
            ggroup_reg     <= ggroup_next;
            glimit_reg     <= glimit_next;
            gcols_reg      <= gcols_next;
            gacc_reg       <= gacc_next;
        end
    end

endmodule

// File: rtl/pccp_fifo.sv
// Short job queue between the front and back parts.
// Depends on pccp_pkg for the job type and depth.
module pccp_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pccp_pkg::job_t wr_job,
    input  logic           pop,
    output pccp_pkg::job_t rd_job,
    output logic           full,
    output logic           empty
);
    import pccp_pkg::*;

    job_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg,  count_next;

    assign full   = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

// File: rtl/pccp_back.sv
// Back part: takes jobs from the queue and sends their results one per transaction.
// Depends on pccp_pkg; owns the registered result channel.
module pccp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  pccp_pkg::job_t q_job,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [39:0]    m_tdata,   // [3:0] command, [27:4] argument, [35:28] repeat_res
    output logic           m_tlast    // last
);
    import pccp_pkg::*;

    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    job_t                 job_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [39:0]          m_tdata_reg;
    logic                 m_tlast_reg;

    logic                 out_free;
    logic                 emit;
    logic                 load;
    logic [NUM_SLOTS-1:0] sel;
    logic [NUM_SLOTS-1:0] rest;
    logic [3:0]           cmd;
    logic [23:0]          arg;
    logic [7:0]           rep;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = out_free && (mask_reg != '0);
    assign sel      = mask_reg & (~mask_reg + 1'b1);
    assign rest     = mask_reg & ~sel;
    assign load     = !q_empty && ((mask_reg == '0) || (emit && rest == '0));
    assign q_pop    = load;

    // Lowest pending slot of the current job
    always_comb begin
        cmd = CMD_USEFONT;
        arg = '0;
        rep = 8'd1;
        if (mask_reg[SLOT_PAGE]) begin
            cmd = CMD_NEWPAGE;
        end else if (mask_reg[SLOT_CRLF]) begin
            cmd = CMD_CRLF;
            rep = job_reg.crlf_rep;
        end else if (mask_reg[SLOT_CR]) begin
            cmd = CMD_CR;
        end else if (mask_reg[SLOT_PAD]) begin
            cmd = CMD_CHAR;
            arg = {16'h0000, BYTE_SPACE};
            rep = job_reg.pad_rep;
        end else if (mask_reg[SLOT_MAIN]) begin
            cmd = job_reg.main_cmd;
            arg = job_reg.main_arg;
        end else begin
            cmd = job_reg.sec_cmd;
            arg = {8'h00, job_reg.sec_arg};
        end
    end

    always_comb begin
        if (load)
            mask_next = q_job.mask;
        else if (emit)
            mask_next = rest;
        else
            mask_next = mask_reg;
        if (emit)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            mask_reg     <= mask_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load)
            job_reg <= q_job;
        if (emit) begin
            m_tdata_reg <= {4'h0, rep, arg, cmd};
            m_tlast_reg <= (rest == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/printer_control_code_parser_unit.sv
// Top level of the printer control code parser: front parser, job queue, result sender.
// Depends on pccp_pkg, pccp_front, pccp_fifo and pccp_back.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  s_       | in  | s_tvalid / s_tready  | s_tdata[7:0] stream_byte
//  m_       | out | m_tvalid / m_tready  | m_tdata command, argument, repeat_res; m_tlast
//  cfg_     | in  | cfg_wr_en            | cfg_index, cfg_wdata[7:0]
//
// A byte is parsed in the cycle it is accepted; a new byte can follow every cycle
// while the four-entry job queue has room. The result sender puts out one result
// per cycle while m_tready is high; a byte causes 0 to 6 results, and a byte
// with none is not queued. The sender's single output port sets the rate.
// Results are registered in the sender before they go out. Reset is synchronous
// and clears parser state, queue and output valid. Stalls on m_tready fill the queue
// and then drop s_tready.
module printer_control_code_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [3:0] command, [27:4] argument, [35:28] repeat_res
    output logic        m_tlast,    // last
    input  logic        cfg_wr_en,
    input  logic        cfg_index,  // 0 page_break_lines, 1 expanded_as_bold
    input  logic [7:0]  cfg_wdata
);
    import pccp_pkg::*;

    job_t push_job;
    job_t pop_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    pccp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (push),
        .q_job     (push_job)
    );

    pccp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (push_job),
        .pop     (pop),
        .rd_job  (pop_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    pccp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_job    (pop_job),
        .q_empty  (q_empty),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
